### sv/ufe_pkg.sv
`default_nettype none

package ufe_pkg;

  localparam int HEADER_LENGTH   = 10;
  localparam int POS_W           = $clog2(HEADER_LENGTH);
  localparam int UFE_QUEUE_DEPTH = 2;

  localparam logic [POS_W-1:0] POS_SEP2 = POS_W'(1);
  localparam logic [POS_W-1:0] POS_SIZE = POS_W'(2);
  localparam logic [POS_W-1:0] POS_FLAG = POS_W'(3);
  localparam logic [POS_W-1:0] POS_TYPE = POS_W'(HEADER_LENGTH - 1);

  localparam logic [7:0]  CRC_FLAG  = 8'h40;
  localparam logic [15:0] CRC_POLY  = 16'hA001;

  localparam logic [7:0] RESET_SEPARATOR = 8'hFF;
  localparam logic [7:0] RESET_STUFF     = 8'h55;
  localparam logic [7:0] RESET_OFFSET    = 8'h08;

  localparam logic [1:0] REG_SEPARATOR = 2'd0;
  localparam logic [1:0] REG_STUFF     = 2'd1;
  localparam logic [1:0] REG_OFFSET    = 2'd2;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  typedef enum logic [1:0] {
    KIND_START,
    KIND_DATA,
    KIND_ERR
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic       use_crc;
    logic [7:0] size;
    logic [7:0] value;
    logic       trailer;
  } desc_t;

  typedef struct packed {
    logic [7:0] separator;
    logic [7:0] stuff;
    logic [7:0] offset;
  } cfg_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### sv/uart_frame_encoder_crc16_stuffing_core.sv
// Byte-stuffed frame encoder with mod-256 checksum and CRC-16/ARC trailer.
// Input channel: in_valid/in_stall with command, frame_type, use_crc,
// payload_len and data_byte. A start request (command 0) emits the
// two-byte preamble and the eight header bytes, plus the trailer when the
// payload length is zero. A data request (command 1) emits one payload byte
// and, after the last payload byte, the checksum and optional CRC bytes.
// Every separator-valued frame byte past the preamble is followed by a stuff byte.
// A data request with no open frame yields one byte 0 with error set.
// Output channel: out_valid/out_stall, one line byte per cycle while
// out_stall is low; last marks the final byte caused by a request.
// A request accepted into an empty queue becomes its head; its first byte
// is then registered onto out_byte. The output byte engine sets throughput
// at one byte per cycle while out_stall is low: a data request emits 1 or 2
// bytes, 2 to 8 with trailer; a start request emits 10 to 18, up to 24 with trailer.
// A QUEUE_DEPTH-entry request queue parts the input from the byte engine,
// so requests are accepted while the engine or the receiver is busy.
// Reset: synchronous, clears the queue, the open-frame state and the
// registers to separator 0xFF, stuff 0x55, size offset 8.
// When out_stall is high, the output byte holds and the queue fills; once
// full, in_stall rises. Write the registers only while the block is idle.
`default_nettype none

module uart_frame_encoder_crc16_stuffing_core import ufe_pkg::*; #(
  parameter int QUEUE_DEPTH = UFE_QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       write_enable,
  input  wire logic [1:0] reg_index,
  input  wire logic [7:0] write_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       command,
  input  wire logic [7:0] frame_type,
  input  wire logic       use_crc,
  input  wire logic [7:0] payload_len,
  input  wire logic [7:0] data_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            last,
  output logic            error
);

  cfg_t  cfg;
  logic  push;
  desc_t push_desc;
  logic  queue_full;
  logic  head_valid;
  desc_t head;
  logic  pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.separator <= RESET_SEPARATOR;
      cfg.stuff     <= RESET_STUFF;
      cfg.offset    <= RESET_OFFSET;
    end else if (write_enable) begin
      case (reg_index)
        REG_SEPARATOR: cfg.separator <= write_data;
        REG_STUFF:     cfg.stuff     <= write_data;
        REG_OFFSET:    cfg.offset    <= write_data;
        default: ;
      endcase
    end
  end

  ufe_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .queue_full  (queue_full),
    .command     (command),
    .frame_type  (frame_type),
    .use_crc     (use_crc),
    .payload_len (payload_len),
    .data_byte   (data_byte),
    .in_stall    (in_stall),
    .push        (push),
    .desc        (push_desc)
  );

  ufe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_desc  (push_desc),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head       (head)
  );

  ufe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .last       (last),
    .error      (error)
  );

endmodule

`default_nettype wire

### sv/ufe_front.sv
`default_nettype none

module ufe_front import ufe_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire logic       in_valid,
  input  wire logic       queue_full,
  input  wire logic       command,
  input  wire logic [7:0] frame_type,
  input  wire logic       use_crc,
  input  wire logic [7:0] payload_len,
  input  wire logic [7:0] data_byte,
  output logic            in_stall,
  output logic            push,
  output desc_t           desc
);

  logic       frame_open;
  logic       frame_open_next;
  logic [7:0] remaining;
  logic [7:0] remaining_next;

  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  always_comb begin
    desc            = '0;
    frame_open_next = frame_open;
    remaining_next  = remaining;
    if (command == CMD_START) begin
      desc.kind       = KIND_START;
      desc.use_crc    = use_crc;
      desc.size       = cfg.offset + payload_len;
      desc.value      = frame_type;
      desc.trailer    = (payload_len == 8'd0);
      remaining_next  = payload_len;
      frame_open_next = (payload_len != 8'd0);
    end else if (!frame_open) begin
      desc.kind = KIND_ERR;
    end else begin
      desc.kind       = KIND_DATA;
      desc.value      = data_byte;
      remaining_next  = remaining - 8'd1;
      desc.trailer    = (remaining_next == 8'd0);
      frame_open_next = (remaining_next != 8'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open <= 1'b0;
      remaining  <= 8'd0;
    end else if (push) begin
      frame_open <= frame_open_next;
      remaining  <= remaining_next;
    end
  end

endmodule

`default_nettype wire

### sv/ufe_queue.sv
`default_nettype none

module ufe_queue import ufe_pkg::*; #(
  parameter int DEPTH = UFE_QUEUE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire desc_t push_desc,
  input  wire logic  pop,
  output logic       full,
  output logic       head_valid,
  output desc_t      head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  desc_t             entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

### sv/ufe_back.sv
`default_nettype none

module ufe_back import ufe_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  head_valid,
  input  wire desc_t head,
  output logic       pop,
  output logic       out_valid,
  input  wire logic  out_stall,
  output logic [7:0] out_byte,
  output logic       last,
  output logic       error
);

  typedef enum logic [2:0] {
    SEG_START,
    SEG_PRE,
    SEG_HDR,
    SEG_DATA,
    SEG_CK,
    SEG_CH,
    SEG_CL,
    SEG_ERR
  } seg_t;

  seg_t             seg;
  seg_t             eff;
  seg_t             seg_next;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic             stuff_pend;
  logic             pend_last;
  logic             pend_count;
  logic             crc_en;
  logic [7:0]       checksum;
  logic [15:0]      crc;

  logic [7:0]       byte_val;
  logic [7:0]       hdr_byte;
  logic             body;
  logic             stuffable;
  logic             seg_end;
  logic             err_val;
  logic             need_stuff;
  logic [7:0]       emit_byte;
  logic             emit_last;
  logic             emit_err;
  logic             fire;

  always_comb begin
    if (pos == POS_SIZE) begin
      hdr_byte = head.size;
    end else if (pos == POS_FLAG) begin
      hdr_byte = crc_en ? CRC_FLAG : 8'h00;
    end else if (pos == POS_TYPE) begin
      hdr_byte = head.value;
    end else begin
      hdr_byte = 8'h00;
    end
  end

  always_comb begin
    eff = seg;
    if (seg == SEG_START) begin
      unique case (head.kind)
        KIND_START: eff = SEG_PRE;
        KIND_DATA:  eff = SEG_DATA;
        KIND_ERR:   eff = SEG_ERR;
        default:    eff = SEG_ERR;
      endcase
    end
  end

  always_comb begin
    byte_val  = 8'h00;
    body      = 1'b0;
    stuffable = 1'b1;
    seg_end   = 1'b0;
    err_val   = 1'b0;
    seg_next  = eff;
    pos_next  = pos;
    unique case (eff)
      SEG_PRE: begin
        byte_val  = cfg.separator;
        stuffable = 1'b0;
        if (pos == POS_SEP2) begin
          seg_next = SEG_HDR;
          pos_next = POS_SIZE;
        end else begin
          pos_next = pos + POS_W'(1);
        end
      end
      SEG_HDR: begin
        byte_val = hdr_byte;
        body     = 1'b1;
        if (pos == POS_TYPE) begin
          seg_end  = !head.trailer;
          seg_next = SEG_CK;
        end else begin
          pos_next = pos + POS_W'(1);
        end
      end
      SEG_DATA: begin
        byte_val = head.value;
        body     = 1'b1;
        seg_end  = !head.trailer;
        seg_next = SEG_CK;
      end
      SEG_CK: begin
        byte_val = checksum;
        seg_end  = !crc_en;
        seg_next = SEG_CH;
      end
      SEG_CH: begin
        byte_val = crc[15:8];
        seg_next = SEG_CL;
      end
      SEG_CL: begin
        byte_val = crc[7:0];
        seg_end  = 1'b1;
      end
      SEG_ERR: begin
        stuffable = 1'b0;
        err_val   = 1'b1;
        seg_end   = 1'b1;
      end
      default: begin
        seg_end = 1'b1;
      end
    endcase
  end

  assign need_stuff = stuffable && (byte_val == cfg.separator);
  assign emit_byte  = stuff_pend ? cfg.stuff : byte_val;
  assign emit_last  = stuff_pend ? pend_last : (seg_end && !need_stuff);
  assign emit_err   = !stuff_pend && err_val;
  assign fire       = head_valid && (!out_valid || !out_stall);
  assign pop        = fire && emit_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg        <= SEG_START;
      pos        <= '0;
      stuff_pend <= 1'b0;
      pend_last  <= 1'b0;
      pend_count <= 1'b0;
      out_valid  <= 1'b0;
      crc_en     <= 1'b1;
      checksum   <= 8'h00;
      crc        <= 16'h0000;
    end else if (fire) begin
      out_valid <= 1'b1;
      out_byte  <= emit_byte;
      last      <= emit_last;
      error     <= emit_err;
      if (stuff_pend) begin
        stuff_pend <= 1'b0;
        if (pend_count) begin
          checksum <= checksum + cfg.stuff;
        end
      end else begin
        stuff_pend <= need_stuff;
        pend_last  <= seg_end;
        pend_count <= body;
        seg        <= seg_end ? SEG_START : seg_next;
        pos        <= seg_end ? '0 : pos_next;
        if (eff == SEG_PRE && pos == '0) begin
          checksum <= 8'h00;
          crc      <= 16'h0000;
          crc_en   <= head.use_crc;
        end else if (body) begin
          checksum <= checksum + byte_val;
          if (crc_en) begin
            crc <= crc16_byte(crc, byte_val);
          end
        end
      end
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

### test/tb_uart_frame_encoder_crc16_stuffing_core.sv
`default_nettype none

module tb_uart_frame_encoder_crc16_stuffing_core import ufe_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       error;
  } line_byte_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       write_enable = 1'b0;
  logic [1:0] reg_index = REG_SEPARATOR;
  logic [7:0] write_data = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       command = CMD_START;
  logic [7:0] frame_type = 8'h00;
  logic       use_crc = 1'b0;
  logic [7:0] payload_len = 8'h00;
  logic [7:0] data_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       last;
  logic       error;

  int sender_gap_pct = 0;
  int receiver_stall_pct = 0;
  int failures = 0;

  line_byte_t expected_line[$];

  logic [7:0]  sep_reg = RESET_SEPARATOR;
  logic [7:0]  stuff_reg = RESET_STUFF;
  logic [7:0]  offset_reg = RESET_OFFSET;
  logic        frame_is_open = 1'b0;
  logic        crc_on = 1'b1;
  logic [7:0]  bytes_left = 8'h00;
  logic [7:0]  checksum_acc = 8'h00;
  logic [15:0] crc_acc = 16'h0000;

  uart_frame_encoder_crc16_stuffing_core dut (
    .clk(clk),
    .rst(rst),
    .write_enable(write_enable),
    .reg_index(reg_index),
    .write_data(write_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .frame_type(frame_type),
    .use_crc(use_crc),
    .payload_len(payload_len),
    .data_byte(data_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte(out_byte),
    .last(last),
    .error(error)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < receiver_stall_pct);
  end

  // bitwise CRC-16/ARC, one data bit per shift
  function automatic logic [15:0] crc_arc_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int k = 0; k < 8; k++) begin
      fb = r[0] ^ b[k];
      r = {1'b0, r[15:1]};
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  function automatic void push_line(input logic [7:0] b, input logic err);
    line_byte_t e;
    e.value = b;
    e.last = 1'b0;
    e.error = err;
    expected_line.push_back(e);
  endfunction

  function automatic void emit_stuffed(input logic [7:0] b, input logic counted);
    push_line(b, 1'b0);
    if (counted) begin
      checksum_acc = checksum_acc + b;
    end
    if (b == sep_reg) begin
      push_line(stuff_reg, 1'b0);
      if (counted) begin
        checksum_acc = checksum_acc + stuff_reg;
      end
    end
  endfunction

  function automatic void emit_body(input logic [7:0] b);
    emit_stuffed(b, 1'b1);
    if (crc_on) begin
      crc_acc = crc_arc_step(crc_acc, b);
    end
  endfunction

  function automatic void emit_trailer();
    emit_stuffed(checksum_acc, 1'b0);
    if (crc_on) begin
      emit_stuffed(crc_acc[15:8], 1'b0);
      emit_stuffed(crc_acc[7:0], 1'b0);
    end
    frame_is_open = 1'b0;
  endfunction

  function automatic void predict_line_bytes(input logic cmd, input logic [7:0] ftype,
                                             input logic crc, input logic [7:0] len,
                                             input logic [7:0] data);
    logic [7:0] hdr;
    line_byte_t tail;
    if (cmd == CMD_START) begin
      crc_on = crc;
      checksum_acc = 8'h00;
      crc_acc = 16'h0000;
      bytes_left = len;
      frame_is_open = 1'b1;
      push_line(sep_reg, 1'b0);
      push_line(sep_reg, 1'b0);
      for (int pos = int'(POS_SIZE); pos < HEADER_LENGTH; pos++) begin
        if (pos == int'(POS_SIZE)) begin
          hdr = offset_reg + len;
        end else if (pos == int'(POS_FLAG)) begin
          hdr = crc_on ? CRC_FLAG : 8'h00;
        end else if (pos == int'(POS_TYPE)) begin
          hdr = ftype;
        end else begin
          hdr = 8'h00;
        end
        emit_body(hdr);
      end
      if (bytes_left == 8'h00) begin
        emit_trailer();
      end
    end else if (!frame_is_open) begin
      push_line(8'h00, 1'b1);
    end else begin
      emit_body(data);
      bytes_left = bytes_left - 8'd1;
      if (bytes_left == 8'h00) begin
        emit_trailer();
      end
    end
    tail = expected_line[expected_line.size() - 1];
    tail.last = 1'b1;
    expected_line[expected_line.size() - 1] = tail;
  endfunction

  always @(posedge clk) begin : check_line
    line_byte_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_line.size() == 0) begin
        $error("unexpected line byte: out_byte=%h last=%b error=%b", out_byte, last, error);
        failures++;
      end else begin
        want = expected_line.pop_front();
        if (out_byte !== want.value) begin
          $error("out_byte mismatch: expected %h, actual %h", want.value, out_byte);
          failures++;
        end
        if (last !== want.last) begin
          $error("last mismatch: expected %b, actual %b", want.last, last);
          failures++;
        end
        if (error !== want.error) begin
          $error("error mismatch: expected %b, actual %b", want.error, error);
          failures++;
        end
      end
    end
  end

  task automatic send_request(input logic cmd, input logic [7:0] ftype, input logic crc,
                              input logic [7:0] len, input logic [7:0] data);
    while ($urandom_range(99) < sender_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    frame_type <= ftype;
    use_crc <= crc;
    payload_len <= len;
    data_byte <= data;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    predict_line_bytes(cmd, ftype, crc, len, data);
  endtask

  task automatic start_frame(input logic [7:0] ftype, input logic crc, input logic [7:0] len);
    send_request(CMD_START, ftype, crc, len, 8'($urandom_range(255)));
  endtask

  task automatic send_data(input logic [7:0] data);
    send_request(CMD_DATA, 8'($urandom_range(255)), 1'($urandom_range(1)),
                 8'($urandom_range(255)), data);
  endtask

  task automatic drain_encoder();
    in_valid <= 1'b0;
    while (expected_line.size() != 0) begin
      @(posedge clk);
    end
    repeat (32) @(posedge clk);
  endtask

  task automatic write_config(input logic [7:0] sep, input logic [7:0] stf,
                              input logic [7:0] ofs);
    write_enable <= 1'b1;
    reg_index <= REG_SEPARATOR;
    write_data <= sep;
    @(posedge clk);
    reg_index <= REG_STUFF;
    write_data <= stf;
    @(posedge clk);
    reg_index <= REG_OFFSET;
    write_data <= ofs;
    @(posedge clk);
    write_enable <= 1'b0;
    sep_reg = sep;
    stuff_reg = stf;
    offset_reg = ofs;
  endtask

  task automatic test_error_without_frame();
    send_data(8'hFF);
    send_data(8'h00);
  endtask

  task automatic test_default_frames();
    start_frame(8'hFF, 1'b1, 8'd0);
    start_frame(8'h00, 1'b0, 8'd3);
    send_data(8'hFF);
    send_data(8'h00);
    send_data(8'h55);
    send_data(8'h12);
    // open a frame and abandon it with a new start
    start_frame(8'hA5, 1'b1, 8'd2);
    send_data(8'h12);
    start_frame(8'h7E, 1'b1, 8'd1);
    send_data(8'hFF);
    // size byte lands on the separator value
    start_frame(8'h3C, 1'b1, 8'hF7);
    send_data(8'hC3);
    start_frame(8'h01, 1'b0, 8'd0);
  endtask

  task automatic test_register_extremes();
    drain_encoder();
    // separator equal to stuff value, maximum size offset
    write_config(8'h00, 8'h00, 8'hFF);
    start_frame(8'h00, 1'b1, 8'd1);
    send_data(8'h00);
    start_frame(8'hFF, 1'b0, 8'd1);
    send_data(8'hFF);
    drain_encoder();
    write_config(8'hFF, 8'hFF, 8'h00);
    start_frame(8'hFF, 1'b1, 8'd2);
    send_data(8'hFF);
    send_data(8'h80);
    drain_encoder();
  endtask

  task automatic test_random_frames(input int gap_pct, input int stall_pct, input int n_items);
    int         sent;
    int         roll;
    int         n_data;
    logic [7:0] len;
    logic [7:0] ftype;
    sent = 0;
    sender_gap_pct = gap_pct;
    receiver_stall_pct = stall_pct;
    while (sent < n_items) begin
      if ($urandom_range(99) < 8) begin
        send_data(8'($urandom_range(255)));
        sent++;
      end else begin
        ftype = ($urandom_range(9) < 3) ? sep_reg : 8'($urandom_range(255));
        roll = $urandom_range(99);
        if (roll < 10) begin
          // broken frame: announce a length, send fewer bytes
          len = 8'($urandom_range(1, 255));
          n_data = $urandom_range(0, (len > 4) ? 4 : len - 1);
        end else begin
          if (roll < 13) begin
            len = 8'($urandom_range(128, 255));
          end else if (roll < 25) begin
            len = 8'($urandom_range(7, 40));
          end else begin
            len = 8'($urandom_range(0, 6));
          end
          n_data = len;
        end
        start_frame(ftype, 1'($urandom_range(1)), len);
        sent++;
        for (int i = 0; i < n_data; i++) begin
          send_data(($urandom_range(3) == 0) ? sep_reg : 8'($urandom_range(255)));
          sent++;
        end
      end
    end
    drain_encoder();
  endtask

  initial begin
    sender_gap_pct = 11;
    receiver_stall_pct = 66;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_error_without_frame();
    test_default_frames();
    test_register_extremes();
    write_config(RESET_SEPARATOR, RESET_STUFF, RESET_OFFSET);
    test_random_frames(11, 66, 110);
    write_config(8'h00, 8'hFF, 8'h00);
    test_random_frames(66, 11, 110);
    write_config(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
    test_random_frames(0, 0, 110);
    if (failures == 0 && expected_line.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
